>>> src/adsreg_pkg.sv
`default_nettype none

package adsreg_pkg;

	localparam int unsigned CFG_DATA_W = 25;
	localparam int unsigned RECIP_W    = 25;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned LVL_W      = 8;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned FRAC_W     = 24;
	localparam int unsigned PROD1_W    = LVL_W + LEN_W;
	localparam int unsigned PROD2_W    = PROD1_W + RECIP_W;

	typedef enum logic [1:0] {
		FUNC_QUERY    = 2'd0,
		FUNC_GATE_ON  = 2'd1,
		FUNC_GATE_OFF = 2'd2,
		FUNC_ADVANCE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_PEAK_VOLUME   = 3'd0,
		REG_ATTACK_LEN    = 3'd1,
		REG_DECAY_LEN     = 3'd2,
		REG_SUSTAIN_LEVEL = 3'd3,
		REG_RELEASE_LEN   = 3'd4,
		REG_ATTACK_RECIP  = 3'd5,
		REG_DECAY_RECIP   = 3'd6,
		REG_RELEASE_RECIP = 3'd7
	} reg_index_t;

	localparam logic [1:0] PH_HELD     = 2'd0;
	localparam logic [1:0] PH_RELEASED = 2'd1;
	localparam logic [1:0] PH_OFF      = 2'd2;

	typedef enum logic [1:0] {
		MODE_FIXED,
		MODE_ATTACK,
		MODE_DECAY,
		MODE_RELEASE
	} env_mode_t;

	typedef struct packed {
		env_mode_t            mode;
		logic [PROD1_W-1:0]   prod;
		logic [LVL_W-1:0]     e_fix;
	} env_cmd_t;

	typedef struct packed {
		logic [TICK_W-1:0] start_stamp;
		logic [TICK_W-1:0] release_stamp;
		logic [1:0]        phase;
	} voice_row_t;

	localparam voice_row_t ROW_RESET = '{
		start_stamp:   '0,
		release_stamp: '0,
		phase:         PH_OFF
	};

endpackage

`default_nettype wire

>>> src/adsr_envelope_generator.sv
`default_nettype none

// Multi-voice ADSR envelope generator. One word in gives one word out: voice memory
// read on acceptance, envelope segment selection with the first multiply, multiply by
// the segment reciprocal, then volume scaling into the output register. The input stays
// stalled until the word has reached the output register, which holds it while the
// output is stalled; the next word is taken while it waits. Voice state sits in one
// memory row per voice, with a valid bit per row so reset needs no clearing pass.
// Configuration must be written only while no word is in flight; this is not enforced.

module adsr_envelope_generator #(
	parameter int unsigned VOICES = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [2:0]                           cfg_index,
	input  wire logic [adsreg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           func,
	input  wire logic [2:0]                           voice,
	input  wire logic                                 pitch_changed,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [adsreg_pkg::LVL_W-1:0]              level,
	output logic [1:0]                                voice_phase
);

	import adsreg_pkg::*;

	localparam int unsigned IW = (VOICES > 1) ? $clog2(VOICES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t                  state_q;
	logic [LVL_W-1:0]        peak_volume_q;
	logic [LEN_W-1:0]        attack_len_q;
	logic [LEN_W-1:0]        decay_len_q;
	logic [LVL_W-1:0]        sustain_level_q;
	logic [LEN_W-1:0]        release_len_q;
	logic [RECIP_W-1:0]      attack_recip_q;
	logic [RECIP_W-1:0]      decay_recip_q;
	logic [RECIP_W-1:0]      release_recip_q;
	logic [TICK_W-1:0]       now_ticks_q;

	voice_row_t              mem [VOICES];
	logic [VOICES-1:0]       row_vld_q;

	voice_row_t              rd_row_s1;
	logic                    rd_vld_s1;
	func_t                   func_s1;
	logic [IW-1:0]           idx_s1;
	logic                    voice_ok_s1;
	logic                    pitch_s1;
	logic [1:0]              phase_s2;
	logic [1:0]              phase_s3;
	func_t                   func_s3;
	env_cmd_t                cmd_s2;

	logic                    in_accept;
	logic [IW-1:0]           in_idx;
	voice_row_t              row_eff;
	voice_row_t              new_row;
	logic                    mem_wr;
	env_cmd_t                cmd_eval;
	logic [1:0]              phase_eval;
	logic [TICK_W-1:0]       t_held;
	logic [TICK_W-1:0]       u_rel;
	logic [LEN_W:0]          a_plus_d;
	logic [LVL_W-1:0]        span;
	logic [LVL_W-1:0]        mul_a;
	logic [LEN_W-1:0]        mul_b;
	logic [LVL_W-1:0]        level_fin;
	logic                    out_free;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_idx    = IW'(voice);
	assign out_free  = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_volume_q   <= 8'd255;
			attack_len_q    <= '0;
			decay_len_q     <= '0;
			sustain_level_q <= '0;
			release_len_q   <= '0;
			attack_recip_q  <= '0;
			decay_recip_q   <= '0;
			release_recip_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_PEAK_VOLUME:   peak_volume_q   <= cfg_data[LVL_W-1:0];
				REG_ATTACK_LEN:    attack_len_q    <= cfg_data[LEN_W-1:0];
				REG_DECAY_LEN:     decay_len_q     <= cfg_data[LEN_W-1:0];
				REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data[LVL_W-1:0];
				REG_RELEASE_LEN:   release_len_q   <= cfg_data[LEN_W-1:0];
				REG_ATTACK_RECIP:  attack_recip_q  <= cfg_data[RECIP_W-1:0];
				REG_DECAY_RECIP:   decay_recip_q   <= cfg_data[RECIP_W-1:0];
				REG_RELEASE_RECIP: release_recip_q <= cfg_data[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_row_s1 <= mem[in_idx];
		end
		if (mem_wr) begin
			mem[idx_s1] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1     <= func_t'(func);
			idx_s1      <= in_idx;
			voice_ok_s1 <= (32'(voice) < 32'(VOICES));
			pitch_s1    <= pitch_changed;
			rd_vld_s1   <= row_vld_q[in_idx];
		end
		if (state_q == ST_EVAL) begin
			cmd_s2   <= cmd_eval;
			phase_s2 <= phase_eval;
		end
		if (state_q == ST_MUL) begin
			phase_s3 <= phase_s2;
			func_s3  <= func_s1;
		end
	end

	always_comb begin
		row_eff    = rd_vld_s1 ? rd_row_s1 : ROW_RESET;
		new_row    = row_eff;
		mem_wr     = 1'b0;
		t_held     = now_ticks_q - row_eff.start_stamp;
		u_rel      = now_ticks_q - row_eff.release_stamp;
		a_plus_d   = {1'b0, attack_len_q} + {1'b0, decay_len_q};
		span       = (peak_volume_q > sustain_level_q) ? (peak_volume_q - sustain_level_q) : '0;
		mul_a      = '0;
		mul_b      = '0;
		cmd_eval.mode  = MODE_FIXED;
		cmd_eval.e_fix = '0;
		if (voice_ok_s1) begin
			case (func_s1)
				FUNC_GATE_ON: begin
					new_row.phase = PH_HELD;
					if (pitch_s1) begin
						new_row.start_stamp = now_ticks_q;
					end
					mem_wr = 1'b1;
				end
				FUNC_GATE_OFF: begin
					if (row_eff.phase == PH_HELD) begin
						new_row.phase         = PH_RELEASED;
						new_row.release_stamp = now_ticks_q;
					end
					new_row.start_stamp = now_ticks_q;
					mem_wr = 1'b1;
				end
				FUNC_QUERY: begin
					if (row_eff.phase == PH_HELD) begin
						if (t_held < TICK_W'(attack_len_q)) begin
							cmd_eval.mode = MODE_ATTACK;
							mul_a = peak_volume_q;
							mul_b = t_held[LEN_W-1:0];
						end else if (t_held < TICK_W'(a_plus_d)) begin
							cmd_eval.mode = MODE_DECAY;
							mul_a = span;
							mul_b = t_held[LEN_W-1:0] - attack_len_q;
						end else begin
							cmd_eval.e_fix = sustain_level_q;
						end
					end else if (row_eff.phase == PH_RELEASED) begin
						if (u_rel < TICK_W'(release_len_q)) begin
							cmd_eval.mode = MODE_RELEASE;
							mul_a = sustain_level_q;
							mul_b = release_len_q - u_rel[LEN_W-1:0];
						end else begin
							new_row.phase = PH_OFF;
							mem_wr = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		mem_wr = mem_wr && (state_q == ST_EVAL);
		cmd_eval.prod = {{LEN_W{1'b0}}, mul_a} * {{LVL_W{1'b0}}, mul_b};
		if (voice_ok_s1 && (new_row.phase == PH_HELD || new_row.phase == PH_RELEASED)) begin
			phase_eval = new_row.phase;
		end else begin
			phase_eval = PH_OFF;
		end
	end

	adsreg_level u_level (
		.clk           (clk),
		.load          (state_q == ST_MUL),
		.cmd           (cmd_s2),
		.peak_volume   (peak_volume_q),
		.attack_recip  (attack_recip_q),
		.decay_recip   (decay_recip_q),
		.release_recip (release_recip_q),
		.level         (level_fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_ticks_q <= '0;
			row_vld_q   <= '0;
			out_valid   <= 1'b0;
			level       <= '0;
			voice_phase <= PH_OFF;
		end else begin
			if (out_valid && !out_stall && state_q != ST_FIN) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (func_s1 == FUNC_ADVANCE) begin
						now_ticks_q <= now_ticks_q + TICK_W'(1);
					end
					if (mem_wr) begin
						row_vld_q[idx_s1] <= 1'b1;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						level       <= level_fin;
						voice_phase <= phase_s3;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##2 state_q == ST_FIN)
		else $error("word did not reach the final stage in time");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && func_s3 != FUNC_QUERY |-> level_fin == '0)
		else $error("non-query word produced a level");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> voice_phase != 2'd3)
		else $error("reserved phase code reported");

endmodule

`default_nettype wire

>>> src/adsreg_level.sv
`default_nettype none

module adsreg_level (
	input  wire logic                             clk,
	input  wire logic                             load,
	input  wire adsreg_pkg::env_cmd_t             cmd,
	input  wire logic [adsreg_pkg::LVL_W-1:0]     peak_volume,
	input  wire logic [adsreg_pkg::RECIP_W-1:0]   attack_recip,
	input  wire logic [adsreg_pkg::RECIP_W-1:0]   decay_recip,
	input  wire logic [adsreg_pkg::RECIP_W-1:0]   release_recip,
	output logic      [adsreg_pkg::LVL_W-1:0]     level
);

	import adsreg_pkg::*;

	logic [RECIP_W-1:0]      recip;
	logic [PROD2_W-1:0]      prod2;
	logic [RECIP_W-1:0]      drop_s3;
	env_mode_t               mode_s3;
	logic [LVL_W-1:0]        e_fix_s3;
	logic [LVL_W-1:0]        env;
	logic [LVL_W-1:0]        env_sat;
	logic [2*LVL_W-1:0]      scaled;
	logic [LVL_W-1:0]        lvl_raw;

	always_comb begin
		case (cmd.mode)
			MODE_ATTACK:  recip = attack_recip;
			MODE_DECAY:   recip = decay_recip;
			MODE_RELEASE: recip = release_recip;
			default:      recip = '0;
		endcase
		prod2 = {{RECIP_W{1'b0}}, cmd.prod} * {{PROD1_W{1'b0}}, recip};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			drop_s3  <= prod2[PROD2_W-1:FRAC_W];
			mode_s3  <= cmd.mode;
			e_fix_s3 <= cmd.e_fix;
		end
	end

	always_comb begin
		env_sat = (drop_s3 > RECIP_W'(255)) ? 8'd255 : drop_s3[LVL_W-1:0];
		case (mode_s3)
			MODE_ATTACK, MODE_RELEASE: env = env_sat;
			MODE_DECAY: env = (drop_s3 < RECIP_W'(peak_volume)) ?
				(peak_volume - drop_s3[LVL_W-1:0]) : '0;
			default: env = e_fix_s3;
		endcase
		scaled  = {{LVL_W{1'b0}}, peak_volume} * {{LVL_W{1'b0}}, env};
		lvl_raw = scaled[2*LVL_W-1:LVL_W];
		level   = (lvl_raw <= LVL_W'(2)) ? '0 : lvl_raw;
	end

endmodule

`default_nettype wire
